// ----- src/ent_pkg.sv -----
// Package for the name entropy threshold check: payload types, register codes,
// fixed widths and the constant functions that build the c*log2(c) tables.
// No dependencies.
package ent_pkg;

  localparam int CHAR_W     = 16;
  localparam int MIN_LEN_W  = 7;
  localparam int THR_W      = 16;
  localparam int CNT_OUT_W  = 7;
  localparam int THR_FRAC   = 12;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 16;

  localparam logic [MIN_LEN_W-1:0] MIN_LENGTH_RST = 7'd8;
  localparam logic [THR_W-1:0]     THRESHOLD_RST  = 16'd15565;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_MIN_LENGTH  = 2'd0,
    CFG_ENTROPY_THR = 2'd1
  } cfg_reg_e;

  typedef struct packed {
    logic [CHAR_W-1:0] character;
    logic              last_char;
  } item_t;

  typedef struct packed {
    logic                 high_entropy;
    logic                 too_short;
    logic                 length_overflow;
    logic [CNT_OUT_W-1:0] char_count;
  } result_t;

  typedef struct packed {
    logic upd;
    logic clr;
  } tab_ctl_t;

  function automatic longint unsigned fixed_log2(int unsigned c, int unsigned frac_bits);
    int unsigned       n;
    longint unsigned   m;
    longint unsigned   frac;
    n    = 0;
    frac = 0;
    if (c == 0) begin
      return 0;
    end
    for (int k = 0; k < 31; k++) begin
      if ((c >> (k + 1)) != 0) begin
        n = k + 1;
      end
    end
    m = (64'(c) << (31 - n)) & 64'hFFFF_FFFF;
    for (int unsigned i = 0; i < frac_bits; i++) begin
      m    = (m * m) >> 31;
      frac = frac << 1;
      if (m >= 64'h1_0000_0000) begin
        m    = m >> 1;
        frac = frac | 64'd1;
      end
    end
    return (64'(n) << frac_bits) | frac;
  endfunction

  function automatic longint unsigned clogc(int unsigned c, int unsigned frac_bits);
    return 64'(c) * fixed_log2(c, frac_bits);
  endfunction

endpackage

// ----- src/ent_stream_if.sv -----
// Valid/ready stream channel with a typed payload.
// Depends on nothing; the payload type comes from the instantiating scope.
interface ent_stream_if #(
  parameter type payload_t = logic
);
  logic     valid;
  logic     ready;
  payload_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

// ----- src/ent_cam.sv -----
// Distinct-character table: parallel match, per-entry counts and allocation.
// Depends on ent_pkg.
module ent_cam #(
  parameter int MAX_LEN = 64,
  parameter int LEN_W   = 7
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  ent_pkg::tab_ctl_t            ctl_i,
  input  logic [ent_pkg::CHAR_W-1:0]   char_i,
  output logic [LEN_W-1:0]             hit_cnt_o
);

  logic [MAX_LEN-1:0]          valid_q;
  logic [ent_pkg::CHAR_W-1:0]  chars_q [MAX_LEN];
  logic [LEN_W-1:0]            cnt_q [MAX_LEN];
  logic [MAX_LEN-1:0]          hit;
  logic [MAX_LEN-1:0]          free;
  logic [MAX_LEN-1:0]          first_free;
  logic                        any_hit;

  always_comb begin
    hit_cnt_o = '0;
    for (int i = 0; i < MAX_LEN; i++) begin
      hit[i] = valid_q[i] && (chars_q[i] == char_i);
      if (hit[i]) begin
        hit_cnt_o = hit_cnt_o | cnt_q[i];
      end
    end
    any_hit    = |hit;
    free       = ~valid_q;
    first_free = free & (~free + MAX_LEN'(1));
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else if (ctl_i.clr) begin
      valid_q <= '0;
    end else if (ctl_i.upd && !any_hit) begin
      valid_q <= valid_q | first_free;
    end
  end

  always_ff @(posedge clk_i) begin
    for (int i = 0; i < MAX_LEN; i++) begin
      if (ctl_i.upd && hit[i]) begin
        cnt_q[i] <= cnt_q[i] + LEN_W'(1);
      end else if (ctl_i.upd && !any_hit && first_free[i]) begin
        chars_q[i] <= char_i;
        cnt_q[i]   <= LEN_W'(1);
      end
    end
  end

endmodule

// ----- src/name_entropy_threshold_check.sv -----
// Top level of the name entropy threshold check.
// Depends on ent_pkg, ent_stream_if and ent_cam.
//
//   Channel     Direction  Payload                                    Transfer
//   item_i      in         character, last_char                       valid & ready
//   result_o    out        high_entropy, too_short, length_overflow,  valid & ready
//                          char_count
//   cfg_*       in         cfg_idx_i, cfg_data_i                      cfg_we_i
//
// One character is taken per cycle while ready is high. A last character passes
// the input register, table update and result register before its result is offered.
// Reset clears the table valid bits, sums and counts at once; no clearing pass.
// A stalled result holds in the output register while characters keep flowing;
// ready drops only when a second finished name is waiting behind it and the
// last character of a third name reaches the input register.
module name_entropy_threshold_check #(
  parameter int MAX_LEN   = 64,
  parameter int FRAC_BITS = 12
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               cfg_we_i,
  input  logic [ent_pkg::CFG_IDX_W-1:0]      cfg_idx_i,
  input  logic [ent_pkg::CFG_DATA_W-1:0]     cfg_data_i,
  ent_stream_if.sink                         item_i,
  ent_stream_if.source                       result_o
);

  localparam int LEN_W     = $clog2(MAX_LEN + 1);
  localparam int IDX_W     = $clog2(MAX_LEN);
  localparam int SUM_W     = $clog2(ent_pkg::clogc(MAX_LEN, FRAC_BITS) + 1);
  localparam int THR_W     = ent_pkg::THR_W;
  localparam int MIN_LEN_W = ent_pkg::MIN_LEN_W;
  localparam int CNT_OUT_W = ent_pkg::CNT_OUT_W;
  localparam int MUL_W     = THR_W + LEN_W;
  localparam int LHS_W     = SUM_W + ent_pkg::THR_FRAC;
  localparam int RHS_W     = MUL_W + FRAC_BITS;
  localparam int CMP_W     = (LHS_W > RHS_W) ? LHS_W : RHS_W;
  localparam int CL_W      = (LEN_W > MIN_LEN_W) ? LEN_W : MIN_LEN_W;

  logic [SUM_W-1:0] clogc_tab [MAX_LEN+1];
  logic [SUM_W-1:0] delta_tab [MAX_LEN];

  for (genvar g = 0; g <= MAX_LEN; g++) begin : g_clogc
    assign clogc_tab[g] = SUM_W'(ent_pkg::clogc(g, FRAC_BITS));
  end
  for (genvar g = 0; g < MAX_LEN; g++) begin : g_delta
    assign delta_tab[g] = SUM_W'(ent_pkg::clogc(g + 1, FRAC_BITS)
                                 - ent_pkg::clogc(g, FRAC_BITS));
  end

  logic [MIN_LEN_W-1:0] min_len_q;
  logic [THR_W-1:0]     thr_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      min_len_q <= ent_pkg::MIN_LENGTH_RST;
      thr_q     <= ent_pkg::THRESHOLD_RST;
    end else if (cfg_we_i) begin
      case (ent_pkg::cfg_reg_e'(cfg_idx_i))
        ent_pkg::CFG_MIN_LENGTH:  min_len_q <= cfg_data_i[MIN_LEN_W-1:0];
        ent_pkg::CFG_ENTROPY_THR: thr_q     <= cfg_data_i[THR_W-1:0];
        default: ;
      endcase
    end
  end

  // Flow control through the three register stages.
  logic a_valid_q, a_valid_d;
  logic fin_valid_q, fin_valid_d;
  logic out_valid_q, out_valid_d;
  logic out_free, fin_go, fin_free, b_go, a_free;

  ent_pkg::item_t   a_item_q;
  ent_pkg::result_t out_q, out_d;

  always_comb begin
    out_free    = !out_valid_q || result_o.ready;
    fin_go      = fin_valid_q && out_free;
    fin_free    = !fin_valid_q || out_free;
    b_go        = a_valid_q && (!a_item_q.last_char || fin_free);
    a_free      = !a_valid_q || b_go;
    a_valid_d   = item_i.valid || (a_valid_q && !b_go);
    fin_valid_d = (fin_valid_q && !out_free) || (b_go && a_item_q.last_char);
    out_valid_d = fin_go || (out_valid_q && !result_o.ready);
  end

  assign item_i.ready = a_free;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_valid_q   <= 1'b0;
      fin_valid_q <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (a_free) begin
        a_valid_q <= a_valid_d;
      end
      fin_valid_q <= fin_valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (a_free && item_i.valid) begin
      a_item_q <= item_i.data;
    end
  end

  // Table update stage.
  logic [SUM_W-1:0] sum_q, sum_d;
  logic [LEN_W-1:0] len_q, len_d;
  logic             ovf_q, ovf_d;
  logic [LEN_W-1:0] hit_cnt;
  logic             counting;
  logic [SUM_W-1:0] sum_add;
  logic [SUM_W-1:0] sum_nxt;
  logic [LEN_W-1:0] len_nxt;
  logic             ovf_nxt;
  ent_pkg::tab_ctl_t tab_ctl;

  always_comb begin
    counting    = len_q < LEN_W'(MAX_LEN);
    tab_ctl.upd = b_go && counting;
    tab_ctl.clr = b_go && a_item_q.last_char;
    sum_add     = counting ? delta_tab[hit_cnt[IDX_W-1:0]] : '0;
    sum_nxt     = sum_q + sum_add;
    len_nxt     = len_q + LEN_W'(counting);
    ovf_nxt     = ovf_q || !counting;
    sum_d       = sum_q;
    len_d       = len_q;
    ovf_d       = ovf_q;
    if (b_go) begin
      if (a_item_q.last_char) begin
        sum_d = '0;
        len_d = '0;
        ovf_d = 1'b0;
      end else begin
        sum_d = sum_nxt;
        len_d = len_nxt;
        ovf_d = ovf_nxt;
      end
    end
  end

  ent_cam #(
    .MAX_LEN (MAX_LEN),
    .LEN_W   (LEN_W)
  ) u_ent_cam (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .ctl_i     (tab_ctl),
    .char_i    (a_item_q.character),
    .hit_cnt_o (hit_cnt)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sum_q <= '0;
      len_q <= '0;
      ovf_q <= 1'b0;
    end else begin
      sum_q <= sum_d;
      len_q <= len_d;
      ovf_q <= ovf_d;
    end
  end

  logic [SUM_W-1:0] fin_sum_q;
  logic [LEN_W-1:0] fin_len_q;
  logic             fin_ovf_q;

  always_ff @(posedge clk_i) begin
    if (b_go && a_item_q.last_char) begin
      fin_sum_q <= sum_nxt;
      fin_len_q <= len_nxt;
      fin_ovf_q <= ovf_nxt;
    end
  end

  // Threshold compare stage.
  logic [SUM_W-1:0] total;
  logic [SUM_W-1:0] diff;
  logic [MUL_W-1:0] prod;
  logic [CMP_W-1:0] lhs, rhs;
  logic             short_name;

  always_comb begin
    total      = clogc_tab[fin_len_q];
    diff       = (total > fin_sum_q) ? (total - fin_sum_q) : '0;
    prod       = MUL_W'(thr_q) * MUL_W'(fin_len_q);
    lhs        = CMP_W'(diff) << ent_pkg::THR_FRAC;
    rhs        = CMP_W'(prod) << FRAC_BITS;
    short_name = CL_W'(fin_len_q) < CL_W'(min_len_q);
    out_d.high_entropy    = !short_name && (lhs >= rhs);
    out_d.too_short       = short_name;
    out_d.length_overflow = fin_ovf_q;
    out_d.char_count      = CNT_OUT_W'(fin_len_q);
  end

  always_ff @(posedge clk_i) begin
    if (fin_go) begin
      out_q <= out_d;
    end
  end

  assign result_o.valid = out_valid_q;
  assign result_o.data  = out_q;

endmodule

// ----- src/ent_checker.sv -----
// Port-level checks for the name entropy threshold check, attached by bind.
// Depends on name_entropy_threshold_check and ent_pkg.
module ent_checker #(
  parameter int MAX_LEN = 64
) (
  input logic                              clk_i,
  input logic                              rst_ni,
  input logic                              res_valid_i,
  input logic                              res_ready_i,
  input logic                              high_entropy_i,
  input logic                              too_short_i,
  input logic                              length_overflow_i,
  input logic [ent_pkg::CNT_OUT_W-1:0]     char_count_i
);

  localparam int CNT_W = ent_pkg::CNT_OUT_W;

  // A result waiting for its transfer stays offered.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_i && !res_ready_i |=> res_valid_i)
    else $error("result withdrawn before its transfer");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_i && high_entropy_i |-> !too_short_i)
    else $error("short name flagged as high entropy");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_i && length_overflow_i |-> char_count_i == CNT_W'(MAX_LEN))
    else $error("overflowed name does not report a full count");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(rst_ni) |-> !res_valid_i)
    else $error("result offered straight out of reset");

endmodule

bind name_entropy_threshold_check ent_checker #(
  .MAX_LEN (MAX_LEN)
) u_ent_checker (
  .clk_i             (clk_i),
  .rst_ni            (rst_ni),
  .res_valid_i       (result_o.valid),
  .res_ready_i       (result_o.ready),
  .high_entropy_i    (result_o.data.high_entropy),
  .too_short_i       (result_o.data.too_short),
  .length_overflow_i (result_o.data.length_overflow),
  .char_count_i      (result_o.data.char_count)
);

// ----- dv/entropy_result_checker.sv -----
// Result checker for the name entropy threshold check: watches the item, result and
// register-write traffic, predicts each name's verdict and compares it with the block.
// Depends on ent_pkg for the payload types, register codes and widths.
module entropy_result_checker
  import ent_pkg::*;
#(
  parameter int NAME_CAP = 64,
  parameter int FRAC     = 12
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i,
  input  logic                  item_valid_i,
  input  logic                  item_ready_i,
  input  item_t                 item_data_i,
  input  logic                  result_valid_i,
  input  logic                  result_ready_i,
  input  result_t               result_data_i,
  output int                    pending_o,
  output int                    fail_count_o
);

  logic [CHAR_W-1:0]    seen_char [NAME_CAP];
  int unsigned          char_tally [NAME_CAP];
  bit                   slot_used [NAME_CAP];
  longint unsigned      clogc_sum;
  int unsigned          name_len;
  bit                   name_overflow;
  logic [MIN_LEN_W-1:0] min_len_q;
  logic [THR_W-1:0]     thr_q;
  result_t              verdicts_owed [$];
  result_t              want;
  int                   failures;

  // Q.FRAC log2 by repeated squaring of a normalized Q1.31 mantissa.
  function automatic longint unsigned log2_q(input int unsigned c);
    int unsigned     msb;
    longint unsigned mant;
    longint unsigned bits;
    msb  = 0;
    bits = 0;
    if (c == 0) begin
      return 0;
    end
    while (msb < 31 && (c >> (msb + 1)) != 0) begin
      msb++;
    end
    mant = (64'(c) << (31 - msb)) & 64'hFFFF_FFFF;
    repeat (FRAC) begin
      mant = (mant * mant) >> 31;
      bits = bits << 1;
      if (mant >= 64'h1_0000_0000) begin
        mant = mant >> 1;
        bits = bits | 64'd1;
      end
    end
    return (64'(msb) << FRAC) | bits;
  endfunction

  function automatic longint unsigned clogc_term(input int unsigned c);
    return 64'(c) * log2_q(c);
  endfunction

  function automatic void clear_name();
    for (int i = 0; i < NAME_CAP; i++) begin
      seen_char[i]  = '0;
      char_tally[i] = 0;
      slot_used[i]  = 1'b0;
    end
    clogc_sum     = 0;
    name_len      = 0;
    name_overflow = 1'b0;
  endfunction

  function automatic void tally_char(input logic [CHAR_W-1:0] ch);
    int free_idx;
    bit hit;
    free_idx = -1;
    hit      = 1'b0;
    if (name_len >= NAME_CAP) begin
      name_overflow = 1'b1;
      return;
    end
    name_len++;
    for (int i = 0; i < NAME_CAP; i++) begin
      if (!hit && slot_used[i] && seen_char[i] == ch) begin
        clogc_sum     = clogc_sum + clogc_term(char_tally[i] + 1) - clogc_term(char_tally[i]);
        char_tally[i] = char_tally[i] + 1;
        hit           = 1'b1;
      end
      if (!hit && !slot_used[i] && free_idx < 0) begin
        free_idx = i;
      end
    end
    if (!hit && free_idx >= 0) begin
      slot_used[free_idx]  = 1'b1;
      seen_char[free_idx]  = ch;
      char_tally[free_idx] = 1;
      clogc_sum            = clogc_sum + clogc_term(1);
    end
  endfunction

  function automatic result_t close_name();
    result_t         r;
    longint unsigned whole;
    longint unsigned spread;
    bit              short_name;
    whole      = clogc_term(name_len);
    spread     = (whole > clogc_sum) ? whole - clogc_sum : 64'd0;
    short_name = name_len < min_len_q;
    r.high_entropy    = !short_name &&
                        ((spread << THR_FRAC) >= ((64'(thr_q) * 64'(name_len)) << FRAC));
    r.too_short       = short_name;
    r.length_overflow = name_overflow;
    r.char_count      = CNT_OUT_W'(name_len);
    clear_name();
    return r;
  endfunction

  function automatic void note_failure(input string msg);
    failures++;
    $display("%0t: %s", $time, msg);
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clear_name();
      min_len_q = MIN_LENGTH_RST;
      thr_q     = THRESHOLD_RST;
      verdicts_owed.delete();
      failures = 0;
      pending_o    <= 0;
      fail_count_o <= 0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_idx_i)
          CFG_MIN_LENGTH: begin
            min_len_q = cfg_data_i[MIN_LEN_W-1:0];
          end
          CFG_ENTROPY_THR: begin
            thr_q = cfg_data_i[THR_W-1:0];
          end
          default: begin
          end
        endcase
      end
      if (item_valid_i && item_ready_i) begin
        tally_char(item_data_i.character);
        if (item_data_i.last_char) begin
          verdicts_owed = {verdicts_owed, close_name()};
        end
      end
      if (result_valid_i && result_ready_i) begin
        if (verdicts_owed.size() == 0) begin
          note_failure($sformatf("result with none expected: expected nothing, got %p",
                                 result_data_i));
        end else begin
          want = verdicts_owed.pop_front();
          if (result_data_i.high_entropy !== want.high_entropy) begin
            note_failure($sformatf("high_entropy expected %0b, got %0b",
                                   want.high_entropy, result_data_i.high_entropy));
          end
          if (result_data_i.too_short !== want.too_short) begin
            note_failure($sformatf("too_short expected %0b, got %0b",
                                   want.too_short, result_data_i.too_short));
          end
          if (result_data_i.length_overflow !== want.length_overflow) begin
            note_failure($sformatf("length_overflow expected %0b, got %0b",
                                   want.length_overflow, result_data_i.length_overflow));
          end
          if (result_data_i.char_count !== want.char_count) begin
            note_failure($sformatf("char_count expected %0d, got %0d",
                                   want.char_count, result_data_i.char_count));
          end
        end
      end
      pending_o    <= verdicts_owed.size();
      fail_count_o <= failures;
    end
  end

endmodule

// ----- dv/tb_name_entropy_threshold_check.sv -----
// Testbench top for the name entropy threshold check: drives base names one character
// per transfer across several register settings, with random idling and back-pressure.
// Depends on ent_pkg, ent_stream_if, the block itself and entropy_result_checker.
module tb_name_entropy_threshold_check;
  import ent_pkg::*;

  localparam int NAME_CAP      = 64;
  localparam int LOG_FRAC      = 12;
  localparam int ITEM_TARGET   = 1750;
  localparam int PHASE_ITEMS   = 220;
  localparam int HOLD_PHASE    = 5;
  localparam int STEADY_PHASE  = 6;
  localparam int HOLD_CYCLES   = 300;
  localparam int SETTLE_CYCLES = 6;
  localparam int IDLE_PERCENT  = 26;

  localparam logic [CFG_IDX_W-1:0] CFG_IDX_UNUSED = 2'd3;

  typedef enum int {
    ALPHA_ANY,
    ALPHA_FEW,
    ALPHA_LOWER,
    ALPHA_DISTINCT
  } alphabet_e;

  logic                  clk_i = 1'b0;
  logic                  rst_ni;
  logic                  cfg_we_i;
  logic [CFG_IDX_W-1:0]  cfg_idx_i;
  logic [CFG_DATA_W-1:0] cfg_data_i;
  int                    results_owed;
  int                    failures;
  int unsigned           items_sent = 0;
  int unsigned           hold_requests = 0;
  int unsigned           hold_served = 0;
  bit                    steady = 1'b0;

  ent_stream_if #(.payload_t(item_t))   item_if ();
  ent_stream_if #(.payload_t(result_t)) result_if ();

  name_entropy_threshold_check #(
    .MAX_LEN   (NAME_CAP),
    .FRAC_BITS (LOG_FRAC)
  ) DUT (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .item_i     (item_if),
    .result_o   (result_if)
  );

  entropy_result_checker #(
    .NAME_CAP (NAME_CAP),
    .FRAC     (LOG_FRAC)
  ) u_result_check (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we_i),
    .cfg_idx_i      (cfg_idx_i),
    .cfg_data_i     (cfg_data_i),
    .item_valid_i   (item_if.valid),
    .item_ready_i   (item_if.ready),
    .item_data_i    (item_if.data),
    .result_valid_i (result_if.valid),
    .result_ready_i (result_if.ready),
    .result_data_i  (result_if.data),
    .pending_o      (results_owed),
    .fail_count_o   (failures)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  initial begin
    #2_000_000;
    $display("tb_name_entropy_threshold_check NOT OK");
    $finish;
  end

  // Result side: random back-pressure, plus a long hold-off on request.
  initial begin
    result_if.ready <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (hold_requests != hold_served) begin
        hold_served = hold_requests;
        result_if.ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk_i);
      end
      result_if.ready <= steady || ($urandom_range(99) >= IDLE_PERCENT);
    end
  end

  task automatic send_char(input logic [CHAR_W-1:0] ch, input logic last);
    while (!steady && $urandom_range(99) < IDLE_PERCENT) begin
      item_if.valid <= 1'b0;
      @(posedge clk_i);
    end
    item_if.valid <= 1'b1;
    item_if.data  <= item_t'{character: ch, last_char: last};
    do begin
      @(posedge clk_i);
    end while (!item_if.ready);
    items_sent++;
  endtask

  task automatic send_name(input int unsigned len);
    logic [CHAR_W-1:0] base;
    logic [CHAR_W-1:0] ch;
    alphabet_e         alphabet;
    int unsigned       spread;
    base     = CHAR_W'($urandom);
    alphabet = alphabet_e'($urandom_range(3));
    spread   = $urandom_range(7);
    for (int unsigned i = 0; i < len; i++) begin
      case (alphabet)
        ALPHA_ANY:      ch = CHAR_W'($urandom);
        ALPHA_FEW:      ch = base + CHAR_W'($urandom_range(spread));
        ALPHA_LOWER:    ch = CHAR_W'(16'h0061 + $urandom_range(25));
        default:        ch = base + CHAR_W'(i);
      endcase
      send_char(ch, i == len - 1);
    end
  endtask

  function automatic int unsigned random_name_len();
    int unsigned pick;
    pick = $urandom_range(99);
    if (pick < 70) begin
      return $urandom_range(1, 16);
    end else if (pick < 88) begin
      return $urandom_range(17, 40);
    end else if (pick < 95) begin
      return $urandom_range(41, NAME_CAP);
    end
    return $urandom_range(NAME_CAP + 1, NAME_CAP + 26);
  endfunction

  // Stop offering characters and wait until every owed result has been taken.
  task automatic drain();
    item_if.valid <= 1'b0;
    @(posedge clk_i);
    while (results_owed != 0) begin
      @(posedge clk_i);
    end
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] value);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= value;
    @(posedge clk_i);
  endtask

  task automatic apply_config(input logic [CFG_DATA_W-1:0] min_word,
                              input logic [CFG_DATA_W-1:0] thr_word);
    write_reg(CFG_IDX_UNUSED, CFG_DATA_W'($urandom));
    write_reg(CFG_MIN_LENGTH, min_word);
    write_reg(CFG_ENTROPY_THR, thr_word);
    cfg_we_i <= 1'b0;
  endtask

  initial begin
    int unsigned           phase_no;
    int unsigned           phase_end;
    logic [CFG_DATA_W-1:0] min_word;
    logic [CFG_DATA_W-1:0] thr_word;
    rst_ni        <= 1'b0;
    cfg_we_i      <= 1'b0;
    cfg_idx_i     <= CFG_MIN_LENGTH;
    cfg_data_i    <= '0;
    item_if.valid <= 1'b0;
    item_if.data  <= '0;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed names under the reset settings.
    send_char(16'h0061, 1'b1);
    send_char(16'h0000, 1'b0);
    send_char(16'hFFFF, 1'b1);
    for (int i = 0; i < 16; i++) begin
      send_char(CHAR_W'(16'h0061 + i), i == 15);
    end
    for (int i = 0; i < 8; i++) begin
      send_char(16'h007A, i == 7);
    end

    phase_no = 0;
    while (items_sent < ITEM_TARGET) begin
      drain();
      case (phase_no)
        0: begin
          min_word = 16'd0;
          thr_word = 16'd0;
        end
        1: begin
          min_word = 16'd64;
          thr_word = 16'hFFFF;
        end
        2: begin
          min_word = 16'hFFFF;
          thr_word = 16'd16384;
        end
        3: begin
          min_word = 16'd4;
          thr_word = 16'd16384;
        end
        4: begin
          min_word = 16'd4;
          thr_word = 16'd16385;
        end
        HOLD_PHASE: begin
          min_word = CFG_DATA_W'(MIN_LENGTH_RST);
          thr_word = THRESHOLD_RST;
        end
        default: begin
          min_word = {9'($urandom), 7'($urandom_range(0, NAME_CAP))};
          thr_word = CFG_DATA_W'($urandom);
        end
      endcase
      apply_config(min_word, thr_word);
      if (phase_no == HOLD_PHASE) begin
        hold_requests <= hold_requests + 1;
        repeat (40) send_name($urandom_range(1, 2));
        drain();
      end
      if (phase_no == STEADY_PHASE) begin
        steady <= 1'b1;
      end
      phase_end = items_sent + PHASE_ITEMS;
      while (items_sent < phase_end) begin
        send_name(random_name_len());
      end
      if (phase_no == STEADY_PHASE) begin
        steady <= 1'b0;
      end
      phase_no++;
    end
    drain();

    if (failures == 0) begin
      $display("tb_name_entropy_threshold_check OK");
    end else begin
      $display("tb_name_entropy_threshold_check NOT OK");
    end
    $finish;
  end

endmodule

// ----- sim.f -----
src/ent_pkg.sv
src/ent_stream_if.sv
src/ent_cam.sv
src/name_entropy_threshold_check.sv
src/ent_checker.sv
dv/entropy_result_checker.sv
dv/tb_name_entropy_threshold_check.sv
